/* sv/assert_macros.svh */
// assertion helper macros for the value noise rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* sv/vn2db_pkg.sv */
// shared types, constants and hash helpers for the 2d value noise unit
// no dependencies
package vn2db_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int COORD_W           = 32;
  localparam int NOISE_W           = 18;
  localparam int IN_TDATA_W        = 96;
  localparam int OUT_TDATA_W       = 24;
  localparam int PIPE_DEPTH        = 9;
  localparam int NUM_CORNERS       = 4;

  localparam logic [31:0] HASH_MUL_Y   = 32'd57;
  localparam logic [31:0] HASH_MUL_S   = 32'd131;
  localparam int          HASH_SHIFT   = 13;
  localparam logic [31:0] HASH_MUL_SQ  = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ  = 32'd789221;
  localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;
  localparam logic [31:0] HASH_MASK    = 32'h7fffffff;
  localparam logic [NOISE_W-1:0] CORNER_ONE = NOISE_W'(65536);

  localparam int NOISE_MIN = -65535;
  localparam int NOISE_MAX = 65536;

  typedef logic [31:0] word_t;
  typedef logic signed [NOISE_W-1:0] noise_t;

  // lattice index mix before the polynomial
  function automatic word_t corner_mix(input word_t cx, input word_t cy, input word_t seed);
    word_t n;
    n = cx + cy * HASH_MUL_Y + seed * HASH_MUL_S;
    return n ^ (n << HASH_SHIFT);
  endfunction

  // corner value 1 - h/2^30 in q1.16
  function automatic noise_t corner_from_hash(input word_t p);
    word_t h;
    h = (p + HASH_ADD_OUT) & HASH_MASK;
    return noise_t'(CORNER_ONE - {1'b0, h[30:14]});
  endfunction

endpackage

/* sv/value_noise_2d_bilinear_unit.sv */
// 2d value noise: lattice hash of four corners and bilinear blend
// depends on vn2db_pkg and assert_macros.svh
// throughput: one item per cycle; the whole pipeline stalls only when the
// output register holds a result that is not taken
// reset (rst_n low, synchronous) clears all stage valid bits; data regs keep
// their contents
`include "assert_macros.svh"

module value_noise_2d_bilinear_unit
  import vn2db_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // x_position [31:0], y_position [63:32], noise_seed [95:64]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // noise_value [17:0], zero [23:18]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PROD_W = FRACTION_BITS + NOISE_W + 2;

  typedef logic [FRACTION_BITS-1:0] frac_t;

  logic                  pipe_en;
  logic [PIPE_DEPTH-1:0] vld_r;

  logic signed [COORD_W-1:0] x_s, y_s;
  word_t ix, iy, ix1, iy1, seed;
  word_t n1_nxt [NUM_CORNERS];

  word_t  n1_r  [NUM_CORNERS];
  word_t  n2_r  [NUM_CORNERS];
  word_t  n3_r  [NUM_CORNERS];
  word_t  sq_r  [NUM_CORNERS];
  word_t  m_r   [NUM_CORNERS];
  word_t  p_r   [NUM_CORNERS];
  noise_t cv_r  [NUM_CORNERS];
  frac_t  fx_r  [5];
  frac_t  fy_r  [7];

  logic signed [NOISE_W:0]   da, db, dy;
  logic signed [PROD_W-1:0]  pa_nxt, pb_nxt, py_nxt;
  logic signed [PROD_W-1:0]  pa_r, pb_r, py_r;
  noise_t va_r, vc_r, i1_r, i2_r, i1b_r, noise_r;

  assign pipe_en    = !vld_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready  = pipe_en;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];
  assign out_tdata  = {{(OUT_TDATA_W-NOISE_W){1'b0}}, noise_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // stage 1: floor split and lattice mix
  always_comb begin
    x_s  = in_tdata[31:0];
    y_s  = in_tdata[63:32];
    seed = in_tdata[95:64];
    ix   = x_s >>> FRACTION_BITS;
    iy   = y_s >>> FRACTION_BITS;
    ix1  = ix + 32'd1;
    iy1  = iy + 32'd1;
    n1_nxt[0] = corner_mix(ix,  iy,  seed);
    n1_nxt[1] = corner_mix(ix1, iy,  seed);
    n1_nxt[2] = corner_mix(ix,  iy1, seed);
    n1_nxt[3] = corner_mix(ix1, iy1, seed);
  end

  // blend products
  always_comb begin
    da     = {cv_r[1][NOISE_W-1], cv_r[1]} - {cv_r[0][NOISE_W-1], cv_r[0]};
    db     = {cv_r[3][NOISE_W-1], cv_r[3]} - {cv_r[2][NOISE_W-1], cv_r[2]};
    dy     = {i2_r[NOISE_W-1], i2_r} - {i1_r[NOISE_W-1], i1_r};
    pa_nxt = $signed({1'b0, fx_r[4]}) * da;
    pb_nxt = $signed({1'b0, fx_r[4]}) * db;
    py_nxt = $signed({1'b0, fy_r[6]}) * dy;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fx_r[0] <= in_tdata[FRACTION_BITS-1:0];
      fy_r[0] <= in_tdata[32+FRACTION_BITS-1:32];
      for (int k = 1; k < 5; k++) fx_r[k] <= fx_r[k-1];
      for (int k = 1; k < 7; k++) fy_r[k] <= fy_r[k-1];
      for (int c = 0; c < NUM_CORNERS; c++) begin
        n1_r[c] <= n1_nxt[c];
        // stage 2: square
        sq_r[c] <= n1_r[c] * n1_r[c];
        n2_r[c] <= n1_r[c];
        // stage 3: scale and offset
        m_r[c]  <= sq_r[c] * HASH_MUL_SQ + HASH_ADD_SQ;
        n3_r[c] <= n2_r[c];
        // stage 4: outer product
        p_r[c]  <= n3_r[c] * m_r[c];
        // stage 5: corner value
        cv_r[c] <= corner_from_hash(p_r[c]);
      end
      // stage 6: x blend products
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      va_r  <= cv_r[0];
      vc_r  <= cv_r[2];
      // stage 7: x blend sums
      i1_r  <= va_r + pa_r[FRACTION_BITS+NOISE_W-1:FRACTION_BITS];
      i2_r  <= vc_r + pb_r[FRACTION_BITS+NOISE_W-1:FRACTION_BITS];
      // stage 8: y blend product
      py_r  <= py_nxt;
      i1b_r <= i1_r;
      // stage 9: output register
      noise_r <= i1b_r + py_r[FRACTION_BITS+NOISE_W-1:FRACTION_BITS];
    end
  end

  `ASSERT_NEXT(a_stall_holds_valids, clk, rst_n, !pipe_en, $stable(vld_r))
  `ASSERT_SAME(a_corner_range, clk, rst_n, vld_r[4], (cv_r[0] >= NOISE_MIN) && (cv_r[0] <= NOISE_MAX) && (cv_r[3] >= NOISE_MIN) && (cv_r[3] <= NOISE_MAX))
  `ASSERT_SAME(a_out_range, clk, rst_n, out_tvalid, (noise_r >= NOISE_MIN) && (noise_r <= NOISE_MAX))

endmodule

/* bench/value_noise_2d_bilinear_unit_test.sv */
// self-checking bench for value_noise_2d_bilinear_unit: directed and random samples
// under changing source and sink idling, predicted by an in-bench lattice hash model
// depends on vn2db_pkg and the value_noise_2d_bilinear_unit rtl
module value_noise_2d_bilinear_unit_test;
  import vn2db_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS   = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  localparam word_t MIX_Y     = 32'd57;
  localparam word_t MIX_SEED  = 32'd131;
  localparam int    XOR_SHIFT = 13;
  localparam word_t POLY_MUL  = 32'd15731;
  localparam word_t POLY_ADD  = 32'd789221;
  localparam word_t POLY_OUT  = 32'd1376312589;
  localparam word_t HASH_KEEP = 32'h7fffffff;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // x_position [31:0], y_position [63:32], noise_seed [95:64]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // noise_value [17:0], zero [23:18]
  logic [OUT_TDATA_W-1:0] out_tdata;

  noise_t expected_noise[$];
  int     fault_count = 0;
  int     quiet_cycles = 0;
  int     feed_idle_pct = 0;
  int     drain_idle_pct = 0;

  value_noise_2d_bilinear_unit #(.FRACTION_BITS(FRAC_BITS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint lattice_value(input word_t cx, input word_t cy, input word_t seed);
    word_t n;
    word_t h;
    n = cx + MIX_Y * cy + MIX_SEED * seed;
    n = n ^ (n << XOR_SHIFT);
    h = (n * (n * n * POLY_MUL + POLY_ADD) + POLY_OUT) & HASH_KEEP;
    return longint'(65536) - longint'(h >> 14);
  endfunction

  // floor-rounded linear blend
  function automatic longint mix_toward(input longint a, input longint b, input longint t);
    longint p;
    p = t * (b - a);
    return a + (p >>> FRAC_BITS);
  endfunction

  function automatic noise_t noise_at(input word_t x, input word_t y, input word_t seed);
    word_t  ix, iy;
    longint fx, fy, v00, v10, v01, v11, row0, row1;
    ix  = word_t'($signed(x) >>> FRAC_BITS);
    iy  = word_t'($signed(y) >>> FRAC_BITS);
    fx  = longint'(x[FRAC_BITS-1:0]);
    fy  = longint'(y[FRAC_BITS-1:0]);
    v00 = lattice_value(ix, iy, seed);
    v10 = lattice_value(ix + 32'd1, iy, seed);
    v01 = lattice_value(ix, iy + 32'd1, seed);
    v11 = lattice_value(ix + 32'd1, iy + 32'd1, seed);
    row0 = mix_toward(v00, v10, fx);
    row1 = mix_toward(v01, v11, fx);
    return noise_t'(mix_toward(row0, row1, fy));
  endfunction

  // sink side ready
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= drain_idle_pct);
  end

  // result check and watchdog, sampled mid-cycle
  always @(negedge clk) begin
    noise_t got;
    noise_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = noise_t'(out_tdata[NOISE_W-1:0]);
        if (expected_noise.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result: noise_value %0d", got);
        end else begin
          want = expected_noise.pop_front();
          if (got !== want || out_tdata[OUT_TDATA_W-1:NOISE_W] !== '0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("mismatch: expected noise_value %0d pad 0, got %0d pad %0h",
                       want, got, out_tdata[OUT_TDATA_W-1:NOISE_W]);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic send_sample(input word_t x, input word_t y, input word_t seed);
    bit taken;
    if (feed_idle_pct > 0 && $urandom_range(99) < feed_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < feed_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {seed, y, x};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    expected_noise.push_back(noise_at(x, y, seed));
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_noise.size() != 0);
  endtask

  task automatic send_random_sample();
    word_t x, y, seed, r;
    seed = $urandom();
    case ($urandom_range(3))
      0: begin
        // near origin, a few lattice cells either way
        r = $urandom();
        x = {{12{r[19]}}, r[19:0]};
        r = $urandom();
        y = {{12{r[19]}}, r[19:0]};
      end
      1: begin
        // on or just below a lattice point
        x = {16'($urandom_range(65535)), ($urandom_range(1) ? 16'h0000 : 16'hffff)};
        y = {16'($urandom_range(65535)), ($urandom_range(1) ? 16'h0000 : 16'hffff)};
      end
      default: begin
        x = $urandom();
        y = $urandom();
      end
    endcase
    send_sample(x, y, seed);
  endtask

  task automatic test_extremes();
    feed_idle_pct  = 0;
    drain_idle_pct = 0;
    send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
    // exact lattice points, zero fraction
    send_sample(32'h0005_0000, 32'h0003_0000, 32'h0000_002a);
    send_sample(32'hfffb_0000, 32'hfffd_0000, 32'h0000_002a);
    // largest fraction
    send_sample(32'h0005_ffff, 32'h0003_ffff, 32'h0000_002a);
    // negative coordinates floor toward minus infinity
    send_sample(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
    send_sample(32'hffff_0000, 32'hffff_8000, 32'h1234_5678);
    send_sample(32'hfffe_8000, 32'h0000_8000, 32'h8765_4321);
    // top lattice index, neighbor formed in 32 bits
    send_sample(32'h7fff_8000, 32'h7fff_8000, 32'hdead_beef);
    send_sample(32'h7fff_0001, 32'h8000_ffff, 32'h0bad_f00d);
    send_sample(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    send_sample(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_sample(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff);
    send_sample(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000);
    send_sample(32'h0000_0001, 32'h0001_0001, 32'hffff_ffff);
    wait_results_done();
  endtask

  task automatic test_slow_sink();
    feed_idle_pct  = 10;
    drain_idle_pct = 64;
    repeat (130) send_random_sample();
    // hold the source until the pipeline has emptied
    wait_results_done();
    repeat (130) send_random_sample();
  endtask

  task automatic test_bursty_source();
    feed_idle_pct  = 64;
    drain_idle_pct = 10;
    repeat (260) send_random_sample();
  endtask

  task automatic test_full_rate();
    feed_idle_pct  = 0;
    drain_idle_pct = 0;
    repeat (280) send_random_sample();
    wait_results_done();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_slow_sink();
    test_bursty_source();
    test_full_rate();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (fault_count == 0 && expected_noise.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
